### src/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV3,
        ST_DIVD,
        ST_DIVD2,
        ST_RESULT
    } tdpt_state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic done;      // one-cycle pulse, results valid from this cycle on
        logic rem_zero;  // remainder of the last division is zero
    } tdpt_div_status_t;

    localparam int unsigned SMALL_PRIME_MAX = 3;  // values up to here need no division
    localparam int unsigned SECOND_PRIME    = 2;
    localparam int unsigned THIRD_PRIME     = 3;
    localparam int unsigned TRIAL_START     = 5;  // first 6k-1 divisor
    localparam int unsigned PAIR_OFFSET     = 2;  // 6k+1 = (6k-1) + 2
    localparam int unsigned TRIAL_STEP      = 6;

endpackage

`default_nettype wire

### src/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat contents (tdata, lowest bit first)
// s_axis    in   candidate [VALUE_WIDTH-1:0], zero padded to bytes
// m_axis    out  prime_flag [0], zero padded to 8 bits
//
// One candidate at a time. Each division runs bit-serially in the divider; the
// search divides once by 3, then by each 6k-1 and 6k+1 divisor in turn, and stops
// at a zero remainder or at a 6k-1 division whose quotient is below the divisor
// (the number of divisions grows with sqrt(candidate)/3).
// Values up to 3 and even values finish without any division.
// Reset (aresetn low, synchronous) drops m_tvalid and returns to idle.
// A held result does not block the next candidate from being accepted.
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // candidate
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata             // prime_flag
);

    localparam logic [VALUE_WIDTH-1:0] SMALL_MAX = VALUE_WIDTH'(SMALL_PRIME_MAX);
    localparam logic [VALUE_WIDTH-1:0] DIV_THREE = VALUE_WIDTH'(THIRD_PRIME);
    localparam logic [VALUE_WIDTH-1:0] ONE       = VALUE_WIDTH'(SECOND_PRIME - 1);
    localparam logic [VALUE_WIDTH-1:0] D_START   = VALUE_WIDTH'(TRIAL_START);
    localparam logic [VALUE_WIDTH-1:0] D_PAIR    = VALUE_WIDTH'(PAIR_OFFSET);
    localparam logic [VALUE_WIDTH-1:0] D_STEP    = VALUE_WIDTH'(TRIAL_STEP);

    tdpt_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   flag_reg, flag_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_flag_reg, m_flag_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_divisor;
    tdpt_div_status_t       div_status;
    logic [VALUE_WIDTH-1:0] div_quotient;

    tdpt_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(v_reg),
        .divisor (div_divisor),
        .status  (div_status),
        .quotient(div_quotient)
    );

    always_comb begin
        state_next   = state_reg;
        v_next       = v_reg;
        d_next       = d_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_flag_next  = m_flag_reg;
        div_start    = 1'b0;
        div_divisor  = DIV_THREE;
        s_tready     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    v_next     = s_tdata[VALUE_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (v_reg <= SMALL_MAX) begin
                    flag_next  = (v_reg > ONE);
                    state_next = ST_RESULT;
                end else if (!v_reg[0]) begin
                    flag_next  = 1'b0;
                    state_next = ST_RESULT;
                end else begin
                    div_start   = 1'b1;
                    div_divisor = DIV_THREE;
                    state_next  = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (div_status.done) begin
                    if (div_status.rem_zero) begin
                        flag_next  = 1'b0;
                        state_next = ST_RESULT;
                    end else begin
                        d_next      = D_START;
                        div_start   = 1'b1;
                        div_divisor = D_START;
                        state_next  = ST_DIVD;
                    end
                end
            end
            ST_DIVD: begin
                if (div_status.done) begin
                    // quotient below d means d*d > v: no divisor left
                    if (div_quotient < d_reg) begin
                        flag_next  = 1'b1;
                        state_next = ST_RESULT;
                    end else if (div_status.rem_zero) begin
                        flag_next  = 1'b0;
                        state_next = ST_RESULT;
                    end else begin
                        div_start   = 1'b1;
                        div_divisor = d_reg + D_PAIR;
                        state_next  = ST_DIVD2;
                    end
                end
            end
            ST_DIVD2: begin
                if (div_status.done) begin
                    if (div_status.rem_zero) begin
                        flag_next  = 1'b0;
                        state_next = ST_RESULT;
                    end else begin
                        d_next      = d_reg + D_STEP;
                        div_start   = 1'b1;
                        div_divisor = d_reg + D_STEP;
                        state_next  = ST_DIVD;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = flag_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        v_reg      <= v_next;
        d_reg      <= d_next;
        flag_reg   <= flag_next;
        m_flag_reg <= m_flag_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_flag_reg};

endmodule

`default_nettype wire

### src/tdpt_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output tdpt_div_status_t            status,
    output logic      [VALUE_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fit;

    always_comb begin
        // shift the next dividend bit in, subtract if the divisor fits
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fit       = (rem_shift >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fit ? diff[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);
    assign quotient        = quo_reg;

endmodule

`default_nettype wire

### dv/prime_flag_checker.sv
`timescale 1ns / 1ps

module prime_flag_checker
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int DATA_WIDTH  = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [DATA_WIDTH-1:0] s_tdata,    // candidate
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,    // prime_flag
    output int                         fail_count,
    output int                         flags_outstanding,
    output int                         flags_checked
);

    localparam int REPORT_MAX = 10;

    bit                     expected_flags[$];
    logic [VALUE_WIDTH-1:0] pending_candidates[$];
    bit                     want_flag;
    logic [VALUE_WIDTH-1:0] cand;

    // 6k+-1 trial division, square bound taken as d <= v / d so it never wraps
    function automatic bit prime_by_trial(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] d;
        if (v <= VALUE_WIDTH'(SMALL_PRIME_MAX))
            return v > VALUE_WIDTH'(1);
        if ((v % VALUE_WIDTH'(SECOND_PRIME)) == '0 || (v % VALUE_WIDTH'(THIRD_PRIME)) == '0)
            return 1'b0;
        for (d = VALUE_WIDTH'(TRIAL_START); d <= v / d; d = d + VALUE_WIDTH'(TRIAL_STEP)) begin
            if ((v % d) == '0 || (v % (d + VALUE_WIDTH'(PAIR_OFFSET))) == '0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_flags     = {expected_flags, prime_by_trial(s_tdata[VALUE_WIDTH-1:0])};
                pending_candidates = {pending_candidates, s_tdata[VALUE_WIDTH-1:0]};
            end
            if (m_tvalid && m_tready) begin
                if (expected_flags.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%t: result beat with nothing pending, got 0x%02h",
                                 $realtime, m_tdata);
                end else begin
                    want_flag = expected_flags.pop_front();
                    cand      = pending_candidates.pop_front();
                    if (m_tdata !== {7'b0, want_flag}) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%t: candidate %0d expected 0x%02h got 0x%02h",
                                     $realtime, cand, {7'b0, want_flag}, m_tdata);
                    end
                end
                flags_checked++;
            end
            flags_outstanding <= expected_flags.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int VALUE_WIDTH  = 64;
    localparam int DATA_WIDTH   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 75;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 6_000_000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;

    int          fail_count;
    int          flags_outstanding;
    int          flags_checked;
    int unsigned cycle_count = 0;
    int          burst_left  = 1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    trial_division_prime_test_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    prime_flag_checker #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_count       (fail_count),
        .flags_outstanding(flags_outstanding),
        .flags_checked    (flags_checked)
    );

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one beat, hold until taken; bursts end in a random gap, which may be zero.
    task automatic offer_candidate(input logic [63:0] v);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 24));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = int'($urandom_range(1, 8));
        end
    endtask

    // Run time grows with the smallest factor, so wide values always carry a small one
    // and only modest values may be prime.
    function automatic logic [63:0] pick_candidate();
        logic [63:0]  r;
        logic [63:0]  p;
        logic [63:0]  q;
        int unsigned  kind;
        r    = {$urandom(), $urandom()};
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            if ($urandom_range(0, 1) == 1)
                return r & ~64'd1;
            return r - (r % 64'd3);
        end
        if (kind < 60) begin
            p = 64'(2 * $urandom_range(2, 48) + 1);
            return r - (r % p);
        end
        if (kind < 85)
            return 64'($urandom_range(0, 131071));
        p = 64'(2 * $urandom_range(2, 200) + 1);
        q = 64'(2 * $urandom_range(2, 200) + 1);
        return p * q;
    endfunction

    initial begin
        logic [63:0] directed_values[$];
        directed_values = '{
            64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd6, 64'd8,
            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'hAAAA_AAAA_AAAA_AAAA,
            64'd5, 64'd7, 64'd9, 64'd25, 64'd35, 64'd49, 64'd121, 64'd169,
            64'd289, 64'd323, 64'h5555_5555_5555_5555, 64'd65521, 64'd65537
        };
        wait (aresetn);
        @(posedge aclk);
        foreach (directed_values[i])
            offer_candidate(directed_values[i]);
        repeat (RANDOM_ITEMS)
            offer_candidate(pick_candidate());
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (flags_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random ready modes, plus one long hold-off so the input backs up.
    initial begin
        int mode;
        int left;
        bit held;
        mode = 0;
        left = 0;
        held = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && flags_checked >= 4) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    mode = int'($urandom_range(0, 2));
                    left = int'($urandom_range(10, 60));
                end
                left--;
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

endmodule
